>>> hdl/thent_pkg.sv
// Shared types and constants of the tile histogram entropy block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package thent_pkg;

    localparam int SAMPLE_W  = 32;
    localparam int BIN_W     = 16;
    localparam int CNT_W     = 17;
    localparam int SQ_W      = 33;
    localparam int LWS_W     = 56;
    localparam int LG_W      = 21;
    localparam int EXP_W     = 5;
    localparam int FRAC_W    = 16;
    localparam int MANT_W    = 31;
    localparam int MA_W      = 33;
    localparam int PROD_W    = 64;
    localparam int SCORE_W   = 40;
    localparam int TAG_W     = 8;
    localparam int STEP_W    = 6;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PW    = 2;

    // sample format codes
    localparam logic FMT_DIRECT = 1'b0;
    localparam logic FMT_UPPER  = 1'b1;

    // one queued item: histogram bin and end-of-tile flag
    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic             last;
    } t_item;

    // queue status seen by the back end
    typedef struct packed {
        logic  valid;
        t_item head;
    } t_qhead;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_RD, S_XSQ, S_LGI, S_LGSQ, S_LGNR, S_TM, S_ACC, S_DIV, S_OUT
    } t_state;

    // which log term the sequencer is working on
    typedef enum logic [1:0] {
        PH_OLD, PH_NEW, PH_TILE
    } t_phase;

endpackage

`default_nettype wire

>>> hdl/thent_front.sv
// Front end: format register, sample-to-bin reduction and input handshake.
// Depends on thent_pkg.
`timescale 1ns / 1ps
`default_nettype none

module thent_front #(
    parameter int HISTOGRAM_BINS = 65536
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_data,
    input  wire logic                          i_valid,
    input  wire logic [thent_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic                          i_last_of_tile,
    output logic                               o_stall,
    input  wire logic                          i_q_full,
    input  wire logic                          i_clearing,
    output logic                               o_push,
    output thent_pkg::t_item                   o_item
);
    import thent_pkg::*;

    logic             r_fmt;
    logic [BIN_W-1:0] w_bin;

    // format register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_DIRECT;
        end else if (i_cfg_we) begin
            r_fmt <= i_cfg_data;
        end
    end

    // bin reduction, saturated to the histogram size
    always_comb begin
        if (r_fmt == FMT_UPPER) begin
            w_bin = i_sample[SAMPLE_W-1:BIN_W];
        end else if (i_sample[SAMPLE_W-1:BIN_W] != '0) begin
            w_bin = '1;
        end else begin
            w_bin = i_sample[BIN_W-1:0];
        end
        if ({1'b0, w_bin} > CNT_W'(HISTOGRAM_BINS - 1)) begin
            w_bin = BIN_W'(HISTOGRAM_BINS - 1);
        end
    end

    assign o_stall     = i_q_full || i_clearing;
    assign o_push      = i_valid && !o_stall;
    assign o_item.bin  = w_bin;
    assign o_item.last = i_last_of_tile;

endmodule

`default_nettype wire

>>> hdl/thent_fifo.sv
// Short item queue between front and back end.
// Depends on thent_pkg.
`timescale 1ns / 1ps
`default_nettype none

module thent_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  thent_pkg::t_item       i_item,
    output logic                   o_full,
    input  wire logic              i_pop,
    output thent_pkg::t_qhead      o_head
);
    import thent_pkg::*;

    t_item              r_mem [FIFO_DEPTH];
    logic [FIFO_PW-1:0] r_wp, r_rp;
    logic [FIFO_PW:0]   r_cnt;
    logic               w_pop;

    assign w_pop = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (FIFO_PW+1)'(i_push) - (FIFO_PW+1)'(w_pop);
        end
    end

    assign o_full       = (r_cnt == (FIFO_PW+1)'(FIFO_DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.head  = r_mem[r_rp];

endmodule

`default_nettype wire

>>> hdl/thent_back.sv
// Back end: histogram memory, log/multiply sequencer, divider and result register.
// Depends on thent_pkg.
`timescale 1ns / 1ps
`default_nettype none

module thent_back #(
    parameter int HISTOGRAM_BINS  = 65536,
    parameter int MAX_TILE_PIXELS = 65536
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  thent_pkg::t_qhead                  i_head,
    output logic                               o_pop,
    output logic                               o_clearing,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [thent_pkg::SCORE_W-1:0]      o_score,
    output logic [thent_pkg::CNT_W-1:0]        o_pixel_count
);
    import thent_pkg::*;

    localparam int AW = $clog2(HISTOGRAM_BINS);
    localparam int DW = TAG_W + CNT_W;

    // index of the top set bit, zero for zero
    function automatic logic [EXP_W-1:0] top_bit(input logic [CNT_W-1:0] x);
        logic [EXP_W-1:0] e;
        e = '0;
        for (int k = 1; k < CNT_W; k++) begin
            if (x[k]) begin
                e = EXP_W'(k);
            end
        end
        return e;
    endfunction

    logic [DW-1:0]      r_hist [HISTOGRAM_BINS];
    logic [DW-1:0]      r_rdata;

    t_state             r_state, n_state;
    t_phase             r_phase, n_phase;
    logic [AW-1:0]      r_bin, n_bin, r_clr, n_clr;
    logic               r_last, n_last;
    logic [TAG_W-1:0]   r_epoch, n_epoch;
    logic [CNT_W-1:0]   r_c, n_c, r_x, n_x, r_tile, n_tile;
    logic [SQ_W-1:0]    r_sq, n_sq, r_sqsum, n_sqsum;
    logic [LWS_W-1:0]   r_lws, n_lws, r_t0, n_t0, r_div, n_div;
    logic [CNT_W-1:0]   r_rem, n_rem;
    logic [EXP_W-1:0]   r_e, n_e;
    logic [FRAC_W-1:0]  r_frac, n_frac;
    logic [MANT_W-1:0]  r_m, n_m;
    logic [STEP_W-1:0]  r_cnt, n_cnt;
    logic [PROD_W-1:0]  r_prod;
    logic               r_ovalid, n_ovalid;
    logic [SCORE_W-1:0] r_score, n_score;
    logic [CNT_W-1:0]   r_pcnt, n_pcnt;

    logic [MA_W-1:0]    w_ma;
    logic [MANT_W-1:0]  w_mb;
    logic               w_rd, w_we;
    logic [AW-1:0]      w_waddr;
    logic [DW-1:0]      w_wdata;
    logic [LG_W-1:0]    w_lg;
    logic [MANT_W:0]    w_sq_m;
    logic [CNT_W:0]     w_rs;
    logic               w_ge;

    assign w_lg   = {r_e, r_frac};
    assign w_sq_m = r_prod[2*MANT_W-1:MANT_W-1];
    assign w_rs   = {r_rem, r_div[LWS_W-1]};
    assign w_ge   = w_rs >= {1'b0, r_x};

    // histogram memory, one read and one write port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_hist[w_waddr] <= w_wdata;
        end
        if (w_rd) begin
            r_rdata <= r_hist[i_head.head.bin[AW-1:0]];
        end
    end

    // shared multiplier, registered
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_XSQ: begin
                w_ma = MA_W'(r_x);
                w_mb = MANT_W'(r_x);
            end
            S_LGSQ: begin
                w_ma = MA_W'(r_m);
                w_mb = r_m;
            end
            S_TM: begin
                w_ma = (r_phase == PH_TILE) ? r_sqsum : r_sq;
                w_mb = MANT_W'(w_lg);
            end
            default: begin
                w_ma = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(w_ma) * PROD_W'(w_mb);
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_epoch  <= TAG_W'(1);
            r_tile   <= '0;
            r_sqsum  <= '0;
            r_lws    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_epoch  <= n_epoch;
            r_tile   <= n_tile;
            r_sqsum  <= n_sqsum;
            r_lws    <= n_lws;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;
        r_bin   <= n_bin;
        r_last  <= n_last;
        r_c     <= n_c;
        r_x     <= n_x;
        r_sq    <= n_sq;
        r_t0    <= n_t0;
        r_div   <= n_div;
        r_rem   <= n_rem;
        r_e     <= n_e;
        r_frac  <= n_frac;
        r_m     <= n_m;
        r_cnt   <= n_cnt;
        r_score <= n_score;
        r_pcnt  <= n_pcnt;
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_bin    = r_bin;
        n_last   = r_last;
        n_clr    = r_clr;
        n_epoch  = r_epoch;
        n_c      = r_c;
        n_x      = r_x;
        n_tile   = r_tile;
        n_sq     = r_sq;
        n_sqsum  = r_sqsum;
        n_lws    = r_lws;
        n_t0     = r_t0;
        n_div    = r_div;
        n_rem    = r_rem;
        n_e      = r_e;
        n_frac   = r_frac;
        n_m      = r_m;
        n_cnt    = r_cnt;
        n_score  = r_score;
        n_pcnt   = r_pcnt;
        n_ovalid = r_ovalid && i_stall;
        o_pop    = 1'b0;
        w_rd     = 1'b0;
        w_we     = 1'b0;
        w_waddr  = r_bin;
        w_wdata  = {r_epoch, r_c + 1'b1};
        unique case (r_state)
            S_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == AW'(HISTOGRAM_BINS - 1)) begin
                    n_epoch = TAG_W'(1);
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    w_rd    = 1'b1;
                    n_bin   = i_head.head.bin[AW-1:0];
                    n_last  = i_head.head.last;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (r_tile < CNT_W'(MAX_TILE_PIXELS)) begin
                    // stale tag means the bin is still empty in this tile
                    n_c     = (r_rdata[DW-1:CNT_W] == r_epoch) ? r_rdata[CNT_W-1:0] : '0;
                    n_x     = n_c;
                    n_phase = PH_OLD;
                    n_state = S_XSQ;
                end else if (r_last) begin
                    n_x     = r_tile;
                    n_phase = PH_TILE;
                    n_state = S_LGI;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_XSQ: begin
                n_state = S_LGI;
            end
            S_LGI: begin
                if (r_phase != PH_TILE) begin
                    n_sq = r_prod[SQ_W-1:0];
                end
                n_e     = top_bit(r_x);
                n_m     = MANT_W'(({{MANT_W{1'b0}}, r_x} << (MANT_W - 1)) >> n_e);
                n_frac  = '0;
                n_cnt   = '0;
                n_state = S_LGSQ;
            end
            S_LGSQ: begin
                n_state = S_LGNR;
            end
            S_LGNR: begin
                // one fraction bit per squaring of the mantissa
                n_frac = {r_frac[FRAC_W-2:0], w_sq_m[MANT_W]};
                n_m    = w_sq_m[MANT_W] ? w_sq_m[MANT_W:1] : w_sq_m[MANT_W-1:0];
                n_cnt  = r_cnt + 1'b1;
                n_state = (r_cnt == STEP_W'(FRAC_W - 1)) ? S_TM : S_LGSQ;
            end
            S_TM: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                unique case (r_phase)
                    PH_OLD: begin
                        n_t0    = r_prod[LWS_W-1:0];
                        n_x     = r_c + 1'b1;
                        n_phase = PH_NEW;
                        n_state = S_XSQ;
                    end
                    PH_NEW: begin
                        w_we    = 1'b1;
                        n_lws   = r_lws - r_t0 + r_prod[LWS_W-1:0];
                        n_sqsum = r_sqsum + SQ_W'({r_c, 1'b1});
                        n_tile  = r_tile + 1'b1;
                        if (r_last) begin
                            n_x     = n_tile;
                            n_phase = PH_TILE;
                            n_state = S_LGI;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        n_rem = '0;
                        n_cnt = '0;
                        if (r_x != '0 && r_prod[LWS_W-1:0] > r_lws) begin
                            n_div   = r_prod[LWS_W-1:0] - r_lws;
                            n_state = S_DIV;
                        end else begin
                            n_div   = '0;
                            n_state = S_OUT;
                        end
                    end
                endcase
            end
            S_DIV: begin
                // restoring division, one quotient bit a cycle
                n_rem   = w_ge ? CNT_W'(w_rs - {1'b0, r_x}) : w_rs[CNT_W-1:0];
                n_div   = {r_div[LWS_W-2:0], w_ge};
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == STEP_W'(LWS_W - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_score  = (r_div[LWS_W-1:SCORE_W] != '0) ? '1 : r_div[SCORE_W-1:0];
                    n_pcnt   = r_x;
                    n_tile   = '0;
                    n_sqsum  = '0;
                    n_lws    = '0;
                    if (r_epoch == '1) begin
                        n_clr   = '0;
                        n_state = S_CLR;
                    end else begin
                        n_epoch = r_epoch + 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_clearing    = (r_state == S_CLR);
    assign o_valid       = r_ovalid;
    assign o_score       = r_score;
    assign o_pixel_count = r_pcnt;

endmodule

`default_nettype wire

>>> hdl/tile_histogram_entropy.sv
// Top level of the tile histogram entropy block: front end, queue, back end.
// Depends on thent_pkg, thent_front, thent_fifo and thent_back.
//
// Usage: one sample per input item on i_sample, i_last_of_tile high on the
// tile's final sample. i_cfg_we/i_cfg_data set the sample format (0 = 16-bit
// direct, 1 = upper 16 bits); write it only while the block is idle.
// The result channel carries o_score (Q.16, saturating) and o_pixel_count.
// Both channels use valid/stall; an item moves when valid is high, stall low.
// Flow: a four-entry queue takes items at once; the back end takes one
// sample at a time and pops the next only when done: a queue pop and a
// histogram read, then for the old and the new count a square, a 16-step
// log2 by mantissa squaring and a scaling multiply with accumulate, all on
// one shared multiplier. A tile's last sample adds a log2 of the pixel count
// with its scaling multiply, a restoring divide and the load of the result
// register.
// Reset: the histogram is swept clear, one bin a cycle, with the input
// stalled; the same sweep runs after every 255th tile, since bins carry an
// 8-bit tile tag. A stalled result holds in its register while the queue
// keeps accepting samples; the next tile's result waits behind it.
`timescale 1ns / 1ps
`default_nettype none

module tile_histogram_entropy #(
    parameter int HISTOGRAM_BINS  = 65536,
    parameter int MAX_TILE_PIXELS = 65536
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_data,
    input  wire logic                           i_valid,
    input  wire logic [thent_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic                           i_last_of_tile,
    output logic                                o_stall,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [thent_pkg::SCORE_W-1:0]       o_score,
    output logic [thent_pkg::CNT_W-1:0]         o_pixel_count
);
    import thent_pkg::*;

    logic   w_full, w_clearing, w_push, w_pop;
    t_item  w_item;
    t_qhead w_head;

    thent_front #(
        .HISTOGRAM_BINS(HISTOGRAM_BINS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .i_sample       (i_sample),
        .i_last_of_tile (i_last_of_tile),
        .o_stall        (o_stall),
        .i_q_full       (w_full),
        .i_clearing     (w_clearing),
        .o_push         (w_push),
        .o_item         (w_item)
    );

    thent_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    thent_back #(
        .HISTOGRAM_BINS  (HISTOGRAM_BINS),
        .MAX_TILE_PIXELS (MAX_TILE_PIXELS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_clearing    (w_clearing),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_score       (o_score),
        .o_pixel_count (o_pixel_count)
    );

endmodule

`default_nettype wire

>>> hdl/thent_checker.sv
// Port-level checks of tile_histogram_entropy, attached by bind.
// Depends on thent_pkg and the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module thent_checker #(
    parameter int MAX_TILE_PIXELS = 65536
) (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           o_valid,
    input wire logic                           i_stall,
    input wire logic [thent_pkg::SCORE_W-1:0]  o_score,
    input wire logic [thent_pkg::CNT_W-1:0]    o_pixel_count
);
    import thent_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_score) && $stable(o_pixel_count))
        else $error("stalled result changed");

    // an empty tile scores zero
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_pixel_count == '0) |-> (o_score == '0))
        else $error("empty tile with nonzero score");

    // pixel count never exceeds the tile limit
    a_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pixel_count <= CNT_W'(MAX_TILE_PIXELS)))
        else $error("pixel count above tile limit");

    // no result right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind tile_histogram_entropy thent_checker #(
    .MAX_TILE_PIXELS(MAX_TILE_PIXELS)
) u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_score       (o_score),
    .o_pixel_count (o_pixel_count)
);

`default_nettype wire
